FILE: design/lpps_pkg.sv
// Package for the list pattern position search core.
// Shared widths, element type, mode codes and control struct; no dependencies.
`default_nettype none

package lpps_pkg;

    localparam int TYPE_W         = 2;
    localparam int VALUE_W        = 32;
    localparam int ELEM_W         = TYPE_W + VALUE_W;
    localparam int POS_W          = 6;
    localparam int MAX_RES        = 64;
    localparam int CNT_W          = $clog2(MAX_RES + 1);
    localparam int DEF_LIST_DEPTH = 64;

    typedef logic [ELEM_W-1:0] elem_t;

    typedef enum logic [1:0] {
        MODE_PAT  = 2'd0,
        MODE_LIST = 2'd1,
        MODE_RPT  = 2'd2,
        MODE_CLR  = 2'd3
    } mode_t;

    // Write-side strobes from the sequencer to the two element stores.
    typedef struct packed {
        logic list_we;
        logic list_clr;
        logic pat_we;
    } mem_ctl_t;

endpackage

`default_nettype wire

FILE: design/lpps_if.sv
// Channel interfaces for the list pattern position search core.
// Depends on lpps_pkg for field types.
`default_nettype none

interface lpps_in_if
    import lpps_pkg::*;
();
    logic                 valid;
    logic                 ready;
    mode_t                mode;
    logic [TYPE_W-1:0]    elem_type;
    logic [VALUE_W-1:0]   elem_value;
    logic                 last;

    modport source (output valid, mode, elem_type, elem_value, last, input ready);
    modport sink   (input valid, mode, elem_type, elem_value, last, output ready);
endinterface

interface lpps_out_if
    import lpps_pkg::*;
();
    logic                 valid;
    logic                 ready;
    logic                 found;
    logic [POS_W-1:0]     position;
    logic                 final_res;

    modport source (output valid, found, position, final_res, input ready);
    modport sink   (input valid, found, position, final_res, output ready);
endinterface

`default_nettype wire

FILE: design/lpps_list_mem.sv
// List element store: one write port, one registered read port, per-entry valid bits.
// An entry that is not valid reads as integer zero. Depends on lpps_pkg.
`default_nettype none

module lpps_list_mem
    import lpps_pkg::*;
#(
    parameter int LIST_DEPTH = DEF_LIST_DEPTH,
    localparam int ADDR_W = $clog2(LIST_DEPTH)
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              we,
    input  wire logic              clr,
    input  wire logic [ADDR_W-1:0] waddr,
    input  wire elem_t             wdata,
    input  wire logic [ADDR_W-1:0] raddr,
    output      elem_t             rdata
);

    elem_t                 mem [LIST_DEPTH];
    logic [LIST_DEPTH-1:0] valid_reg;
    elem_t                 rdata_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (clr)
        begin
            valid_reg <= '0;
        end
        else if (we)
        begin
            valid_reg[waddr] <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= valid_reg[raddr] ? mem[raddr] : '0;
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

FILE: design/lpps_pat_mem.sv
// Pattern element store: one write port, one registered read port.
// Contents are undefined until written. Depends on lpps_pkg.
`default_nettype none

module lpps_pat_mem
    import lpps_pkg::*;
#(
    parameter int LIST_DEPTH = DEF_LIST_DEPTH,
    localparam int ADDR_W = $clog2(LIST_DEPTH)
) (
    input  wire logic              clk,
    input  wire logic              we,
    input  wire logic [ADDR_W-1:0] waddr,
    input  wire elem_t             wdata,
    input  wire logic [ADDR_W-1:0] raddr,
    output      elem_t             rdata
);

    elem_t mem [LIST_DEPTH];
    elem_t rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

FILE: design/lpps_ctrl.sv
// Sequencer for the list pattern position search: load bookkeeping, the
// shared element comparator walk, and the result register. Depends on lpps_pkg.
`default_nettype none

module lpps_ctrl
    import lpps_pkg::*;
#(
    parameter int LIST_DEPTH = DEF_LIST_DEPTH,
    localparam int ADDR_W = $clog2(LIST_DEPTH),
    localparam int LEN_W  = $clog2(LIST_DEPTH + 1)
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              wrap_enable,
    input  wire logic              in_valid,
    input  wire mode_t             in_mode,
    input  wire logic              in_last,
    output      logic              in_ready,
    input  wire logic              out_ready,
    output      logic              out_valid,
    output      logic              out_found,
    output      logic [POS_W-1:0]  out_pos,
    output      logic              out_final,
    output      mem_ctl_t          mem_ctl,
    output      logic [ADDR_W-1:0] list_waddr,
    output      logic [ADDR_W-1:0] pat_waddr,
    output      logic [ADDR_W-1:0] list_raddr,
    output      logic [ADDR_W-1:0] pat_raddr,
    input  wire elem_t             list_rdata,
    input  wire elem_t             pat_rdata
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ISSUE,
        ST_CHECK,
        ST_PUSH,
        ST_DONE
    } state_t;

    localparam logic [LEN_W-1:0] DEPTH_L = LEN_W'(LIST_DEPTH);
    localparam logic [LEN_W-1:0] ONE_L   = LEN_W'(1);

    state_t           state_reg, state_next;
    logic [LEN_W-1:0] list_len_reg, list_len_next;
    logic [LEN_W-1:0] pat_len_reg, pat_len_next;
    logic [LEN_W-1:0] list_fill_reg, list_fill_next;
    logic [LEN_W-1:0] pat_fill_reg, pat_fill_next;
    logic [LEN_W-1:0] start_reg, start_next;
    logic [LEN_W-1:0] idx_reg, idx_next;
    logic [LEN_W-1:0] at_reg, at_next;
    logic [LEN_W-1:0] end_reg, end_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             pend_valid_reg, pend_valid_next;
    logic [POS_W-1:0] pend_pos_reg, pend_pos_next;
    logic             out_valid_reg, out_valid_next;
    logic             out_found_reg, out_found_next;
    logic [POS_W-1:0] out_pos_reg, out_pos_next;
    logic             out_final_reg, out_final_next;

    logic             accept;
    logic             slot_free;
    logic             list_room;
    logic             pat_room;
    logic [LEN_W-1:0] pat_fill_inc;
    logic [LEN_W-1:0] list_fill_inc;
    logic             start_search;
    logic [LEN_W-1:0] plen_sel;
    logic [LEN_W-1:0] start_inc;
    logic [LEN_W-1:0] at_inc;
    logic             start_last;

    assign accept        = in_valid && (state_reg == ST_IDLE);
    assign slot_free     = !out_valid_reg || out_ready;
    assign list_room     = list_fill_reg < DEPTH_L;
    assign pat_room      = pat_fill_reg < DEPTH_L;
    assign list_fill_inc = list_room ? list_fill_reg + ONE_L : list_fill_reg;
    assign pat_fill_inc  = pat_room ? pat_fill_reg + ONE_L : pat_fill_reg;
    assign start_inc     = start_reg + ONE_L;
    assign at_inc        = at_reg + ONE_L;
    assign start_last    = (start_inc == end_reg);

    always_comb
    begin
        start_search = 1'b0;
        plen_sel     = pat_len_reg;
        if (accept)
        begin
            case (in_mode)
                MODE_PAT:
                begin
                    start_search = in_last;
                    plen_sel     = pat_fill_inc;
                end
                MODE_RPT: start_search = 1'b1;
                default:  start_search = 1'b0;
            endcase
        end
    end

    always_comb
    begin
        state_next      = state_reg;
        list_len_next   = list_len_reg;
        pat_len_next    = pat_len_reg;
        list_fill_next  = list_fill_reg;
        pat_fill_next   = pat_fill_reg;
        start_next      = start_reg;
        idx_next        = idx_reg;
        at_next         = at_reg;
        end_next        = end_reg;
        cnt_next        = cnt_reg;
        pend_valid_next = pend_valid_reg;
        pend_pos_next   = pend_pos_reg;
        out_valid_next  = out_valid_reg && !out_ready;
        out_found_next  = out_found_reg;
        out_pos_next    = out_pos_reg;
        out_final_next  = out_final_reg;
        mem_ctl         = '0;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    case (in_mode)
                        MODE_PAT:
                        begin
                            mem_ctl.pat_we = pat_room;
                            pat_fill_next  = pat_fill_inc;
                            if (in_last)
                            begin
                                pat_len_next  = pat_fill_inc;
                                pat_fill_next = '0;
                            end
                        end
                        MODE_LIST:
                        begin
                            mem_ctl.list_we = list_room;
                            list_fill_next  = list_fill_inc;
                            if (in_last)
                            begin
                                list_len_next  = list_fill_inc;
                                list_fill_next = '0;
                            end
                        end
                        MODE_CLR:
                        begin
                            mem_ctl.list_clr = 1'b1;
                            list_len_next    = '0;
                            list_fill_next   = '0;
                        end
                        default:
                        begin
                        end
                    endcase
                end
                if (start_search)
                begin
                    start_next      = '0;
                    idx_next        = '0;
                    at_next         = '0;
                    cnt_next        = '0;
                    pend_valid_next = 1'b0;
                    end_next        = wrap_enable ? list_len_reg
                                                  : list_len_reg - plen_sel + ONE_L;
                    if (plen_sel == '0 || plen_sel > list_len_reg)
                    begin
                        state_next = ST_DONE;
                    end
                    else
                    begin
                        state_next = ST_ISSUE;
                    end
                end
            end
            ST_ISSUE:
            begin
                state_next = ST_CHECK;
            end
            ST_CHECK:
            begin
                if (pat_rdata != list_rdata)
                begin
                    idx_next   = '0;
                    start_next = start_inc;
                    at_next    = start_inc;
                    state_next = start_last ? ST_DONE : ST_ISSUE;
                end
                else if (idx_reg + ONE_L == pat_len_reg)
                begin
                    state_next = ST_PUSH;
                end
                else
                begin
                    idx_next   = idx_reg + ONE_L;
                    at_next    = (at_inc == list_len_reg) ? '0 : at_inc;
                    state_next = ST_ISSUE;
                end
            end
            ST_PUSH:
            begin
                // Release the held match, hold the new one until its successor shows or the search ends.
                if (!pend_valid_reg || slot_free)
                begin
                    if (pend_valid_reg)
                    begin
                        out_valid_next = 1'b1;
                        out_found_next = 1'b1;
                        out_pos_next   = pend_pos_reg;
                        out_final_next = 1'b0;
                    end
                    pend_valid_next = 1'b1;
                    pend_pos_next   = POS_W'(start_reg);
                    cnt_next        = cnt_reg + CNT_W'(1);
                    idx_next        = '0;
                    start_next      = start_inc;
                    at_next         = start_inc;
                    if (cnt_reg == CNT_W'(MAX_RES - 1) || start_last)
                    begin
                        state_next = ST_DONE;
                    end
                    else
                    begin
                        state_next = ST_ISSUE;
                    end
                end
            end
            ST_DONE:
            begin
                if (slot_free)
                begin
                    out_valid_next = 1'b1;
                    out_found_next = pend_valid_reg;
                    out_pos_next   = pend_valid_reg ? pend_pos_reg : '0;
                    out_final_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            list_len_reg   <= ONE_L;
            pat_len_reg    <= '0;
            list_fill_reg  <= '0;
            pat_fill_reg   <= '0;
            start_reg      <= '0;
            idx_reg        <= '0;
            at_reg         <= '0;
            end_reg        <= '0;
            cnt_reg        <= '0;
            pend_valid_reg <= 1'b0;
            pend_pos_reg   <= '0;
            out_valid_reg  <= 1'b0;
            out_found_reg  <= 1'b0;
            out_pos_reg    <= '0;
            out_final_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            list_len_reg   <= list_len_next;
            pat_len_reg    <= pat_len_next;
            list_fill_reg  <= list_fill_next;
            pat_fill_reg   <= pat_fill_next;
            start_reg      <= start_next;
            idx_reg        <= idx_next;
            at_reg         <= at_next;
            end_reg        <= end_next;
            cnt_reg        <= cnt_next;
            pend_valid_reg <= pend_valid_next;
            pend_pos_reg   <= pend_pos_next;
            out_valid_reg  <= out_valid_next;
            out_found_reg  <= out_found_next;
            out_pos_reg    <= out_pos_next;
            out_final_reg  <= out_final_next;
        end
    end

    assign in_ready   = (state_reg == ST_IDLE);
    assign out_valid  = out_valid_reg;
    assign out_found  = out_found_reg;
    assign out_pos    = out_pos_reg;
    assign out_final  = out_final_reg;
    assign list_waddr = list_fill_reg[ADDR_W-1:0];
    assign pat_waddr  = pat_fill_reg[ADDR_W-1:0];
    assign list_raddr = at_reg[ADDR_W-1:0];
    assign pat_raddr  = idx_reg[ADDR_W-1:0];

endmodule

`default_nettype wire

FILE: design/list_pattern_position_search_core.sv
// List pattern position search core: top level.
// List/pattern element loads and clears are taken while idle; a search walks each element
// compare through an issue state (memory read) then a check state (compare), plus a push
// state per match, bounded by the single shared comparator walk.
// Throughput: one element transaction per cycle while loading; no input during a search.
// Reset: async active low; list reads as one integer zero entry, pattern empty, wrap off.
`default_nettype none

module list_pattern_position_search_core
    import lpps_pkg::*;
#(
    parameter int LIST_DEPTH = DEF_LIST_DEPTH
) (
    input  wire logic  clk,
    input  wire logic  rst_n,
    lpps_in_if.sink    in_ch,
    lpps_out_if.source out_ch,
    input  wire logic  cfg_we,
    input  wire logic  cfg_wdata
);

    localparam int ADDR_W = $clog2(LIST_DEPTH);

    // Wrap control register; the user must write it only while the core is idle (not enforced here).
    logic wrap_enable_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wrap_enable_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            wrap_enable_reg <= cfg_wdata;
        end
    end

    mem_ctl_t          mem_ctl;
    logic [ADDR_W-1:0] list_waddr;
    logic [ADDR_W-1:0] pat_waddr;
    logic [ADDR_W-1:0] list_raddr;
    logic [ADDR_W-1:0] pat_raddr;
    elem_t             list_rdata;
    elem_t             pat_rdata;
    elem_t             in_word;

    // Type tag and raw value compare as one word, so floats match bitwise.
    assign in_word = {in_ch.elem_type, in_ch.elem_value};

    // Sequencer: load bookkeeping, comparator walk, result register.
    lpps_ctrl #(
        .LIST_DEPTH (LIST_DEPTH)
    ) u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .wrap_enable (wrap_enable_reg),
        .in_valid    (in_ch.valid),
        .in_mode     (in_ch.mode),
        .in_last     (in_ch.last),
        .in_ready    (in_ch.ready),
        .out_ready   (out_ch.ready),
        .out_valid   (out_ch.valid),
        .out_found   (out_ch.found),
        .out_pos     (out_ch.position),
        .out_final   (out_ch.final_res),
        .mem_ctl     (mem_ctl),
        .list_waddr  (list_waddr),
        .pat_waddr   (pat_waddr),
        .list_raddr  (list_raddr),
        .pat_raddr   (pat_raddr),
        .list_rdata  (list_rdata),
        .pat_rdata   (pat_rdata)
    );

    // List store; clear drops all valid bits at once, so entries read as integer zero.
    lpps_list_mem #(
        .LIST_DEPTH (LIST_DEPTH)
    ) u_list_mem (
        .clk   (clk),
        .rst_n (rst_n),
        .we    (mem_ctl.list_we),
        .clr   (mem_ctl.list_clr),
        .waddr (list_waddr),
        .wdata (in_word),
        .raddr (list_raddr),
        .rdata (list_rdata)
    );

    // Pattern store; only entries below the pattern length are ever read.
    lpps_pat_mem #(
        .LIST_DEPTH (LIST_DEPTH)
    ) u_pat_mem (
        .clk   (clk),
        .we    (mem_ctl.pat_we),
        .waddr (pat_waddr),
        .wdata (in_word),
        .raddr (pat_raddr),
        .rdata (pat_rdata)
    );

endmodule

`default_nettype wire

FILE: tb/sv/tb_list_pattern_position_search_core.sv
`timescale 1ns / 100ps
// Self-checking testbench for list_pattern_position_search_core: random list/pattern traffic,
// an in-bench match predictor and an in-order check of every result transaction.
// Depends on lpps_pkg and the lpps_in_if / lpps_out_if channel interfaces.

module tb_list_pattern_position_search_core;
    import lpps_pkg::*;

    localparam int DEPTH      = DEF_LIST_DEPTH;
    localparam int MAX_GAP    = 13;
    localparam int IDLE_SPINS = 2_000_000;

    // One input transaction as queued for the driver.
    typedef struct {
        mode_t              mode;
        logic [TYPE_W-1:0]  etype;
        logic [VALUE_W-1:0] value;
        logic               last;
    } word_cmd_t;

    // One expected result transaction.
    typedef struct packed {
        logic             found;
        logic [POS_W-1:0] position;
        logic             final_res;
    } match_res_t;

    logic clk = 1'b0;
    logic rst_n;
    logic cfg_we;
    logic cfg_wdata;

    lpps_in_if  in_ch ();
    lpps_out_if out_ch ();

    list_pattern_position_search_core #(
        .LIST_DEPTH (DEPTH)
    ) DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_ch     (in_ch),
        .out_ch    (out_ch),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    always #5 clk = ~clk;

    // Pending input transactions and expected result transactions.
    word_cmd_t  cmd_q[$];
    match_res_t match_q[$];

    // Predictor copy of the block state.
    elem_t list_mem[DEPTH];
    elem_t pat_mem[DEPTH];
    int    list_len;
    int    pat_len;
    int    list_fill;
    int    pat_fill;
    bit    wrap_on;

    // Generator side: what the last full list load is meant to hold, used to build
    // patterns that actually hit.
    elem_t shadow_list[$];

    int err_count;
    int cmd_count;
    bit no_idle;
    int gap_left;
    int stall_left;
    word_cmd_t next_cmd;
    match_res_t want;

    task automatic report_error(string msg);
        err_count++;
        $display("%0t ERROR %s", $time, msg);
    endtask

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    // Walk every candidate start; a start matches when each pattern word equals the
    // list word at the (possibly wrapped) offset, tag and raw bits alike.
    function automatic void predict_matches();
        int         stop;
        int         hits;
        int         at;
        bit         ok;
        bit         have_prev;
        match_res_t prev;
        match_res_t res;

        // Empty pattern, or pattern longer than the list: a single not-found.
        if (pat_len == 0 || pat_len > list_len)
        begin
            res = '{found: 1'b0, position: '0, final_res: 1'b1};
            match_q.push_back(res);
            return;
        end
        stop = wrap_on ? list_len : list_len - pat_len + 1;
        hits = 0;
        have_prev = 1'b0;
        prev = '0;
        for (int s = 0; s < stop && hits < MAX_RES; s++)
        begin
            ok = 1'b1;
            for (int i = 0; i < pat_len && ok; i++)
            begin
                at = s + i;
                if (at >= list_len)
                    at -= list_len;
                if (at >= DEPTH || pat_mem[i] != list_mem[at])
                    ok = 1'b0;
            end
            if (ok)
            begin
                // Hold each hit back one step so the last one can be marked final.
                if (have_prev)
                    match_q.push_back(prev);
                prev = '{found: 1'b1, position: s[POS_W-1:0], final_res: 1'b0};
                have_prev = 1'b1;
                hits++;
            end
        end
        if (have_prev)
        begin
            prev.final_res = 1'b1;
            match_q.push_back(prev);
        end
        else
        begin
            res = '{found: 1'b0, position: '0, final_res: 1'b1};
            match_q.push_back(res);
        end
    endfunction

    function automatic void predict_word_cmd(mode_t mode, elem_t word, logic last);
        case (mode)
            MODE_PAT:
            begin
                // Words past the store depth are dropped; the length saturates.
                if (pat_fill < DEPTH)
                begin
                    pat_mem[pat_fill] = word;
                    pat_fill++;
                end
                if (last)
                begin
                    pat_len  = pat_fill;
                    pat_fill = 0;
                    predict_matches();
                end
            end
            MODE_LIST:
            begin
                if (list_fill < DEPTH)
                begin
                    list_mem[list_fill] = word;
                    list_fill++;
                end
                if (last)
                begin
                    list_len  = list_fill;
                    list_fill = 0;
                end
            end
            MODE_RPT: predict_matches();
            MODE_CLR:
            begin
                foreach (list_mem[k])
                    list_mem[k] = '0;
                list_len  = 0;
                list_fill = 0;
            end
            default: ;
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Driver: feed the input channel from cmd_q with random gaps
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            in_ch.valid <= 1'b0;
            gap_left = 0;
        end
        else
        begin
            // Predict on the accepted transaction, using the values seen at this edge.
            if (in_ch.valid && in_ch.ready)
                predict_word_cmd(in_ch.mode, {in_ch.elem_type, in_ch.elem_value}, in_ch.last);
            // Advance only when the channel holds nothing, or its transaction just went.
            if (!in_ch.valid || in_ch.ready)
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    in_ch.valid <= 1'b0;
                end
                else if (cmd_q.size() > 0)
                begin
                    next_cmd = cmd_q.pop_front();
                    in_ch.mode       <= next_cmd.mode;
                    in_ch.elem_type  <= next_cmd.etype;
                    in_ch.elem_value <= next_cmd.value;
                    in_ch.last       <= next_cmd.last;
                    in_ch.valid      <= 1'b1;
                    // Draw the idle time that follows this transaction.
                    gap_left = no_idle ? 0 : $urandom_range(0, MAX_GAP);
                end
                else
                begin
                    in_ch.valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Monitor: stall the output channel at random, check every result
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            out_ch.ready <= 1'b0;
            stall_left = 0;
        end
        else
        begin
            if (out_ch.valid && out_ch.ready)
            begin
                if (match_q.size() == 0)
                begin
                    report_error($sformatf("unexpected result found=%0b pos=%0d final=%0b",
                                           out_ch.found, out_ch.position, out_ch.final_res));
                end
                else
                begin
                    want = match_q.pop_front();
                    if (out_ch.found !== want.found)
                        report_error($sformatf("found: got %0b, want %0b",
                                               out_ch.found, want.found));
                    if (out_ch.position !== want.position)
                        report_error($sformatf("position: got %0d, want %0d",
                                               out_ch.position, want.position));
                    if (out_ch.final_res !== want.final_res)
                        report_error($sformatf("final_res: got %0b, want %0b (pos %0d)",
                                               out_ch.final_res, want.final_res,
                                               want.position));
                end
                stall_left = no_idle ? 0 : $urandom_range(0, MAX_GAP);
            end
            if (stall_left > 0)
            begin
                stall_left--;
                out_ch.ready <= 1'b0;
            end
            else
            begin
                out_ch.ready <= 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    task automatic push_cmd(mode_t mode, elem_t word, logic last);
        word_cmd_t c;
        c.mode  = mode;
        c.etype = word[ELEM_W-1:VALUE_W];
        c.value = word[VALUE_W-1:0];
        c.last  = last;
        cmd_q.push_back(c);
        cmd_count++;
    endtask

    // Mostly a small alphabet so patterns hit; sometimes full-range words and odd tags.
    function automatic elem_t rand_word();
        logic [TYPE_W-1:0]  t;
        logic [VALUE_W-1:0] v;
        case ($urandom_range(0, 9))
            0:
            begin
                t = TYPE_W'($urandom_range(0, 3));
                v = $urandom;
            end
            1:
            begin
                t = TYPE_W'($urandom_range(0, 3));
                v = $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'h8000_0000;
            end
            default:
            begin
                t = TYPE_W'($urandom_range(0, 1));
                v = $urandom_range(0, 2);
            end
        endcase
        return {t, v};
    endfunction

    // Load a full list; the shadow keeps what fits in the store.
    task automatic send_list(int n, bit uniform);
        elem_t e;
        elem_t first;
        shadow_list.delete();
        first = rand_word();
        for (int i = 0; i < n; i++)
        begin
            e = uniform ? first : rand_word();
            if (i < DEPTH)
                shadow_list.push_back(e);
            push_cmd(MODE_LIST, e, i == n - 1);
        end
    endtask

    // Pattern mostly cut from the shadow list, wrapping around its end, with noise.
    task automatic send_pattern(int n);
        int    len;
        int    start;
        elem_t e;
        len = shadow_list.size();
        start = (len > 0) ? $urandom_range(0, len - 1) : 0;
        for (int i = 0; i < n; i++)
        begin
            if (len > 0 && $urandom_range(0, 7) != 0)
                e = shadow_list[(start + i) % len];
            else
                e = rand_word();
            push_cmd(MODE_PAT, e, i == n - 1);
        end
    endtask

    function automatic int pick_list_len();
        int r;
        r = $urandom_range(0, 19);
        if (r < 16)
            return $urandom_range(1, 12);
        if (r < 19)
            return $urandom_range(13, 40);
        return DEPTH;
    endfunction

    function automatic int pick_pat_len();
        int r;
        int len;
        r = $urandom_range(0, 9);
        len = (shadow_list.size() > 0) ? shadow_list.size() : 1;
        if (r < 7)
            return $urandom_range(1, 3);
        if (r < 9)
            return $urandom_range(1, len);
        // Longer than the list.
        return len + $urandom_range(1, 2);
    endfunction

    // Hold until every queued transaction went in and every result came out,
    // then let the last non-result transaction settle.
    task automatic wait_idle();
        int spins;
        spins = 0;
        @(negedge clk);
        while ((cmd_q.size() != 0 || in_ch.valid || match_q.size() != 0) &&
               spins < IDLE_SPINS)
        begin
            @(negedge clk);
            spins++;
        end
        if (spins >= IDLE_SPINS)
            report_error($sformatf("no progress: %0d expected results outstanding",
                                   match_q.size()));
        repeat (4) @(negedge clk);
    endtask

    task automatic set_wrap(bit on);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= on;
        @(posedge clk);
        cfg_we    <= 1'b0;
        wrap_on = on;
    endtask

    // One random scenario: mostly well-formed list+pattern searches, plus repeats,
    // clears, half-finished loads, overfull loads and raw noise.
    task automatic run_scenario();
        int    sel;
        int    n;
        bit    same;
        sel = $urandom_range(0, 19);
        if (sel <= 7)
        begin
            send_list(pick_list_len(), 1'b0);
            send_pattern(pick_pat_len());
        end
        else if (sel <= 11)
        begin
            send_pattern(pick_pat_len());
        end
        else if (sel <= 13)
        begin
            push_cmd(MODE_RPT, rand_word(), 1'($urandom_range(0, 1)));
        end
        else if (sel == 14)
        begin
            push_cmd(MODE_CLR, rand_word(), 1'($urandom_range(0, 1)));
            shadow_list.delete();
            if ($urandom_range(0, 1))
                push_cmd(MODE_RPT, rand_word(), 1'b0);
        end
        else if (sel == 15)
        begin
            // Unfinished list load: a repeat sees the overwritten entries.
            n = $urandom_range(1, 4);
            for (int i = 0; i < n; i++)
                push_cmd(MODE_LIST, rand_word(), 1'b0);
            push_cmd(MODE_RPT, rand_word(), 1'b1);
        end
        else if (sel == 16)
        begin
            n = $urandom_range(1, 3);
            for (int i = 0; i < n; i++)
                push_cmd(MODE_PAT, rand_word(), 1'b0);
            push_cmd(MODE_RPT, rand_word(), 1'b0);
        end
        else if (sel == 17)
        begin
            // Overfull list; a uniform one gives the full set of matches.
            same = 1'($urandom_range(0, 1));
            send_list($urandom_range(DEPTH + 1, DEPTH + 6), same);
            if (same)
                push_cmd(MODE_PAT, shadow_list[0], 1'b1);
            else
                send_pattern(pick_pat_len());
        end
        else if (sel == 18)
        begin
            send_pattern($urandom_range(DEPTH + 1, DEPTH + 3));
        end
        else
        begin
            n = $urandom_range(1, 3);
            for (int i = 0; i < n; i++)
                push_cmd(mode_t'($urandom_range(0, 3)), rand_word(),
                         1'($urandom_range(0, 1)));
        end
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial
    begin
        // Known levels on every block input from time zero.
        rst_n            = 1'b0;
        cfg_we           = 1'b0;
        cfg_wdata        = 1'b0;
        in_ch.valid      = 1'b0;
        in_ch.mode       = MODE_PAT;
        in_ch.elem_type  = '0;
        in_ch.elem_value = '0;
        in_ch.last       = 1'b0;
        out_ch.ready     = 1'b0;
        err_count = 0;
        cmd_count = 0;
        no_idle   = 1'b0;

        // Predictor reset state: one integer-zero list entry, no pattern, wrap off.
        foreach (list_mem[k])
            list_mem[k] = '0;
        foreach (pat_mem[k])
            pat_mem[k] = '0;
        list_len  = 1;
        pat_len   = 0;
        list_fill = 0;
        pat_fill  = 0;
        wrap_on   = 1'b0;
        shadow_list.delete();
        shadow_list.push_back('0);

        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed part, wrap off.
        push_cmd(MODE_RPT, '0, 1'b0);                            // empty pattern
        push_cmd(MODE_PAT, {2'd0, 32'h0}, 1'b1);                 // hits the reset list
        push_cmd(MODE_LIST, {2'd3, 32'hFFFF_FFFF}, 1'b0);        // unused tag
        push_cmd(MODE_LIST, {2'd1, 32'h3F80_0000}, 1'b0);        // float 1.0
        push_cmd(MODE_LIST, {2'd2, 32'h0000_0000}, 1'b0);
        push_cmd(MODE_LIST, {2'd0, 32'h0000_0000}, 1'b1);
        push_cmd(MODE_PAT, {2'd1, 32'h3F80_0000}, 1'b1);         // float hit
        push_cmd(MODE_PAT, {2'd0, 32'h3F80_0000}, 1'b1);         // same bits, other tag
        push_cmd(MODE_PAT, {2'd0, 32'h0}, 1'b1);
        push_cmd(MODE_PAT, {2'd0, 32'h0}, 1'b0);                 // needs wrap to hit
        push_cmd(MODE_PAT, {2'd3, 32'hFFFF_FFFF}, 1'b1);
        for (int i = 0; i < 5; i++)                              // longer than the list
            push_cmd(MODE_PAT, {2'd3, 32'hFFFF_FFFF}, i == 4);
        wait_idle();

        // The wrap lookup again with wrap on, then an empty list and a two-entry list.
        set_wrap(1'b1);
        push_cmd(MODE_PAT, {2'd0, 32'h0}, 1'b0);
        push_cmd(MODE_PAT, {2'd3, 32'hFFFF_FFFF}, 1'b1);
        push_cmd(MODE_CLR, '0, 1'b0);
        push_cmd(MODE_RPT, '0, 1'b0);
        push_cmd(MODE_LIST, {2'd0, 32'h0}, 1'b0);
        push_cmd(MODE_LIST, {2'd0, 32'h0}, 1'b1);
        push_cmd(MODE_PAT, {2'd0, 32'h0}, 1'b1);                 // two hits
        shadow_list.delete();
        shadow_list.push_back('0);
        shadow_list.push_back('0);
        wait_idle();

        // Random phases: wrap off when even, on or random when odd; two run with no idling.
        for (int ph = 0; ph < 6; ph++)
        begin
            set_wrap((ph % 2) == 0 ? 1'b0 :
                     ((ph == 3) ? 1'b1 : 1'($urandom_range(0, 1))));
            no_idle = (ph == 1 || ph == 4);
            cmd_count = 0;
            while (cmd_count < 60)
                run_scenario();
            wait_idle();
        end

        // Let any stray result show up, then settle.
        no_idle = 1'b0;
        repeat (20) @(posedge clk);
        while (match_q.size() > 0)
        begin
            want = match_q.pop_front();
            report_error($sformatf("missing result found=%0b pos=%0d final=%0b",
                                   want.found, want.position, want.final_res));
        end
        if (err_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    // Hard stop: far beyond the slowest correct run.
    initial
    begin
        #200_000_000;
        $display("== FAIL ==");
        $finish;
    end

endmodule

FILE: filelist.f
design/lpps_pkg.sv
design/lpps_if.sv
design/lpps_list_mem.sv
design/lpps_pat_mem.sv
design/lpps_ctrl.sv
design/list_pattern_position_search_core.sv
tb/sv/tb_list_pattern_position_search_core.sv
